/* sv/aes128_block_decrypt_assert.svh */
// Assertion macros for the AES-128 decryption pipeline.
// Included by modules that check their own control logic; needs clk and rst in scope.
`ifndef AES128_BLOCK_DECRYPT_ASSERT_SVH
`define AES128_BLOCK_DECRYPT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define AESD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define AESD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* sv/aesd_pkg.sv */
// Shared types, tables and round functions for the AES-128 decryption block.
// No dependencies; used by the round cell, the key cell and the top level.
`default_nettype none

package aesd_pkg;

  localparam int ROUNDS = 10;
  localparam int BUSY_W = 4;
  localparam int CFG_INDEX_W = 8;

  typedef logic [127:0] block_t;
  typedef logic [7:0] byte_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 8'd1;

  localparam byte_t SBOX_TABLE [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam byte_t INV_SBOX_TABLE [0:255] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Round constants of the key schedule, for rounds 1 to 10.
  localparam byte_t RCON_TABLE [1:10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Multiplication by x in GF(2^8).
  function automatic byte_t xtime(input byte_t a);
    xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  // Inverse mix-columns on one column, first byte in the top bits.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    byte_t a [4];
    byte_t m2 [4];
    byte_t m4 [4];
    byte_t m8 [4];
    byte_t m9 [4];
    byte_t m11 [4];
    byte_t m13 [4];
    byte_t m14 [4];
    for (int i = 0; i < 4; i++) begin
      a[i]   = col[31-8*i -: 8];
      m2[i]  = xtime(a[i]);
      m4[i]  = xtime(m2[i]);
      m8[i]  = xtime(m4[i]);
      m9[i]  = m8[i] ^ a[i];
      m11[i] = m8[i] ^ m2[i] ^ a[i];
      m13[i] = m8[i] ^ m4[i] ^ a[i];
      m14[i] = m8[i] ^ m4[i] ^ m2[i];
    end
    inv_mix_col = {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                   m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                   m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                   m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic block_t inv_mix_columns(input block_t st);
    block_t res;
    for (int c = 0; c < 4; c++) begin
      res[127-32*c -: 32] = inv_mix_col(st[127-32*c -: 32]);
    end
    inv_mix_columns = res;
  endfunction

  // Inverse shift-rows followed by the inverse S-box; state bytes are column-major.
  function automatic block_t inv_shift_sub(input block_t st);
    block_t res;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = r + 4 * ((c - r + 4) % 4);
        res[127-8*(r+4*c) -: 8] = INV_SBOX_TABLE[st[127-8*src -: 8]];
      end
    end
    inv_shift_sub = res;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX_TABLE[w[31:24]], SBOX_TABLE[w[23:16]],
                SBOX_TABLE[w[15:8]], SBOX_TABLE[w[7:0]]};
  endfunction

endpackage

`default_nettype wire

/* sv/aesd_key_cell.sv */
// One link of the key schedule chain: derives round key ROUND from the previous one.
// Depends on aesd_pkg for the S-box and round constants.
`default_nettype none

module aesd_key_cell #(
  parameter int ROUND = 1
) (
  input  wire logic            clk,
  input  wire aesd_pkg::block_t prev_key,
  output aesd_pkg::block_t      round_key
);
  import aesd_pkg::*;

  logic [31:0] rot_sub;
  logic [31:0] w0;
  logic [31:0] w1;
  logic [31:0] w2;
  logic [31:0] w3;

  // Rotate, substitute and fold in the round constant, then chain the words.
  always_comb begin
    rot_sub = sub_word({prev_key[23:0], prev_key[31:24]}) ^ {RCON_TABLE[ROUND], 24'h0};
    w0 = prev_key[127:96] ^ rot_sub;
    w1 = prev_key[95:64] ^ w0;
    w2 = prev_key[63:32] ^ w1;
    w3 = prev_key[31:0] ^ w2;
  end

  // The chain recomputes every cycle; it settles one link per cycle after a key write.
  always_ff @(posedge clk) begin
    round_key <= {w0, w1, w2, w3};
  end

endmodule

`default_nettype wire

/* sv/aesd_round_cell.sv */
// One decryption round stage: round-key add, optional inverse mix-columns,
// inverse shift-rows and inverse S-box, then a register. Depends on aesd_pkg.
`default_nettype none

module aesd_round_cell #(
  parameter bit MIX = 1'b1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             in_valid,
  input  wire aesd_pkg::block_t in_state,
  input  wire aesd_pkg::block_t round_key,
  output logic                  out_valid,
  output aesd_pkg::block_t      out_state
);
  import aesd_pkg::*;

  block_t keyed;
  block_t mixed;

  // Round function.
  always_comb begin
    keyed = in_state ^ round_key;
    mixed = MIX ? inv_mix_columns(keyed) : keyed;
  end

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // State of the stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= inv_shift_sub(mixed);
    end
  end

endmodule

`default_nettype wire

/* sv/aes128_block_decrypt.sv */
// AES-128 block decryption, one block per cycle through a row of ten round stages
// while in_stall is low. A ciphertext block passes through the ten round stages and
// then the output register that adds the last round key. One block can enter in every
// cycle that in_stall is low. After reset and after each key register write the key
// schedule chain settles one round key per cycle, and in_stall stays high until
// the settling counter is zero. While the result in the output register is stalled
// the whole row holds and in_stall is high. Keys are written as two 64-bit halves,
// index 0 for bytes 0 to 7 and index 1 for bytes 8 to 15; other indexes are ignored.
// Depends on aesd_pkg, aesd_round_cell, aesd_key_cell and the assertion header.
`default_nettype none

`include "aes128_block_decrypt_assert.svh"

module aes128_block_decrypt (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [aesd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [63:0]                        cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [63:0]                        cipher_high,
  input  wire logic [63:0]                        cipher_low,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [63:0]                             plain_high,
  output logic [63:0]                             plain_low
);
  import aesd_pkg::*;

  logic [63:0]       key_high;
  logic [63:0]       key_low;
  logic [BUSY_W-1:0] busy;
  logic              key_write;
  logic              advance;
  block_t            round_keys [0:ROUNDS];
  block_t            stage_state [0:ROUNDS];
  logic [ROUNDS:0]   stage_valid;

  assign key_write = cfg_write && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= 64'h0;
      key_low  <= 64'h0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Settling counter for the key schedule.
  always_ff @(posedge clk) begin
    if (rst || key_write) begin
      busy <= BUSY_W'(ROUNDS);
    end else if (busy != '0) begin
      busy <= busy - 1'b1;
    end
  end

  // Key schedule chain.
  assign round_keys[0] = {key_high, key_low};
  for (genvar r = 1; r <= ROUNDS; r++) begin : g_key
    aesd_key_cell #(.ROUND(r)) u_key (
      .clk       (clk),
      .prev_key  (round_keys[r-1]),
      .round_key (round_keys[r])
    );
  end

  // The row moves unless a finished result is waiting.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = (busy != '0) || !advance;

  assign stage_valid[0] = in_valid && !in_stall;
  assign stage_state[0] = {cipher_high, cipher_low};

  // Round stages; the first skips inverse mix-columns.
  for (genvar k = 0; k < ROUNDS; k++) begin : g_round
    aesd_round_cell #(.MIX(k != 0)) u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (stage_valid[k]),
      .in_state  (stage_state[k]),
      .round_key (round_keys[ROUNDS-k]),
      .out_valid (stage_valid[k+1]),
      .out_state (stage_state[k+1])
    );
  end

  // Output register with the final round-key add.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      {plain_high, plain_low} <= stage_state[ROUNDS] ^ round_keys[0];
    end
  end

  // Checks on the control logic.
  `AESD_ASSERT_NEXT(a_key_write_busy, key_write, busy == BUSY_W'(ROUNDS),
    "key write did not restart the settling count")
  `AESD_ASSERT_IMPL(a_no_transfer_busy, busy != '0, !stage_valid[0],
    "block transferred while the key schedule was settling")
  `AESD_ASSERT_NEXT(a_row_holds, out_valid && out_stall, $stable(stage_valid[ROUNDS:1]),
    "round stages moved while the result was stalled")
  `AESD_ASSERT_IMPL(a_busy_range, 1'b1, busy <= BUSY_W'(ROUNDS),
    "settling count out of range")

endmodule

`default_nettype wire
